// ===== sv/rmv_pkg.sv =====
// shared types and constants for the running mean / variance block
// no dependencies; compile first
`timescale 1ns / 1ps
`default_nettype none

package rmv_pkg;

    // fixed field widths of the item channels
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 32;
    localparam int MEAN_W   = 32;
    localparam int VAR_W    = 48;

    // sum of squared deviations and the shared adder
    localparam int M2_W  = 64;
    localparam int ALU_W = M2_W + 1;

    // parameter defaults
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF  = 32;

    typedef enum logic [0:0] {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAG1,
        S_DIV1,
        S_MEAN,
        S_MAG2,
        S_MUL,
        S_ACC,
        S_DEC,
        S_DIV2,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== sv/rmv_in_if.sv =====
// input item channel: valid/ready handshake with one sample
// depends on rmv_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rmv_in_if;
    import rmv_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== sv/rmv_out_if.sv =====
// result item channel: valid/ready handshake with count, mean and variance
// depends on rmv_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rmv_out_if;
    import rmv_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] sample_count;
    logic [MEAN_W-1:0]  running_mean;
    logic [VAR_W-1:0]   sample_variance;

    modport source (output valid, output sample_count, output running_mean,
                    output sample_variance, input ready);
    modport sink (input valid, input sample_count, input running_mean,
                  input sample_variance, output ready);
endinterface

`default_nettype wire

// ===== sv/running_mean_variance.sv =====
// running mean and sample variance by welford's update, fixed point
// depends on rmv_pkg, rmv_in_if, rmv_out_if, rmv_alu
//
// i_in carries one unsigned sample per item; o_out carries the new count,
// the mean (Q16.16) and the sample variance m2/(count-1) (Q32.16) for it.
// every accepted item yields exactly one result item, in order.
// one item at a time: i_in.ready is high only while the sequencer is idle.
// a single shared add/subtract unit does all work, one step per cycle, except
// while the result load waits: magnitude, mean divide, mean update, magnitude,
// shift-add multiply, m2 add, divisor setup, variance divide, result load.
// divisor setup and variance divide are skipped while count is at most 1.
// the next item is taken once the sequencer is back in idle after the result
// loads. the variance divide is the longest step at the defaults.
// the result sits in an output register; a stalled receiver only holds the
// sequencer at its last step if a previous result is still waiting there.
// synchronous reset clears count, mean and m2 and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module running_mean_variance #(
    parameter int SAMPLE_BITS = rmv_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = rmv_pkg::FRAC_BITS_DEF,
    parameter int COUNT_BITS  = rmv_pkg::COUNT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmv_in_if.sink     i_in,
    rmv_out_if.source  o_out
);
    import rmv_pkg::*;

    localparam int XW  = SAMPLE_BITS + FRAC_BITS;
    localparam int SIN = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int DW  = M2_W;
    localparam int PW  = 2 * XW;
    localparam int SAT = M2_W + FRAC_BITS;
    localparam int EW  = (PW > SAT) ? PW : SAT + 1;
    localparam int SW  = $clog2(DW + 1);

    t_state                r_state, n_state;
    logic [SW-1:0]         r_step, n_step;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [COUNT_BITS-1:0] r_dvs, n_dvs;
    logic [COUNT_BITS-1:0] r_rem, n_rem;
    logic [XW-1:0]         r_mean, n_mean;
    logic [XW-1:0]         r_x, n_x;
    logic [XW-1:0]         r_mag, n_mag;
    logic                  r_neg, n_neg;
    logic [M2_W-1:0]       r_m2, n_m2;
    logic [DW-1:0]         r_dq, n_dq;
    logic [PW-1:0]         r_prod, n_prod;
    logic                  r_ov, n_ov;
    logic [COUNT_W-1:0]    r_ocnt, n_ocnt;
    logic [MEAN_W-1:0]     r_omean, n_omean;
    logic [VAR_W-1:0]      r_ovar, n_ovar;

    logic [SAMPLE_BITS-1:0] w_samp;
    logic [XW-1:0]          w_xin;
    logic                   w_lt;
    logic                   w_ge;
    logic                   w_low_cnt;
    logic [EW-1:0]          w_ext;
    logic                   w_ovf;
    logic [M2_W-1:0]        w_inc;
    logic [COUNT_BITS:0]    w_part;
    logic [ALU_W-1:0]       w_a, w_b;
    t_alu_op                w_op;
    logic [ALU_W:0]         w_sum;

    rmv_alu u_alu (
        .i_a   (w_a),
        .i_b   (w_b),
        .i_op  (w_op),
        .o_sum (w_sum)
    );

    assign w_samp    = SAMPLE_BITS'(i_in.sample[SIN-1:0]);
    assign w_xin     = {w_samp, {FRAC_BITS{1'b0}}};
    assign w_lt      = r_x < r_mean;
    assign w_ge      = w_sum[ALU_W];
    assign w_low_cnt = (r_cnt >> 1) == '0;
    assign w_part    = {r_rem, r_dq[DW-1]};

    // product >> FRAC_BITS, saturated to the m2 width
    assign w_ext = EW'(r_prod);
    assign w_ovf = |(w_ext >> SAT);
    assign w_inc = w_ovf ? '1 : w_ext[SAT-1:FRAC_BITS];

    // operand selection for the shared unit
    always_comb begin
        w_a  = '0;
        w_b  = '0;
        w_op = ALU_ADD;
        unique case (r_state)
            S_MAG1, S_MAG2: begin
                w_op = ALU_SUB;
                w_a  = ALU_W'(w_lt ? r_mean : r_x);
                w_b  = ALU_W'(w_lt ? r_x : r_mean);
            end
            S_DIV1, S_DIV2: begin
                w_op = ALU_SUB;
                w_a  = ALU_W'(w_part);
                w_b  = ALU_W'(r_dvs);
            end
            S_MEAN: begin
                w_op = r_neg ? ALU_SUB : ALU_ADD;
                w_a  = ALU_W'(r_mean);
                w_b  = ALU_W'(r_dq[XW-1:0]);
            end
            S_MUL: begin
                w_a = ALU_W'(r_prod[PW-1:XW]);
                w_b = r_prod[0] ? ALU_W'(r_mag) : '0;
            end
            S_ACC: begin
                w_a = ALU_W'(r_m2);
                w_b = ALU_W'(w_inc);
            end
            S_DEC: begin
                w_op = ALU_SUB;
                w_a  = ALU_W'(r_cnt);
                w_b  = ALU_W'(1'b1);
            end
            default: begin
                w_a  = '0;
                w_b  = '0;
                w_op = ALU_ADD;
            end
        endcase
    end

    // sequencer: next state and datapath updates
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_cnt   = r_cnt;
        n_dvs   = r_dvs;
        n_rem   = r_rem;
        n_mean  = r_mean;
        n_x     = r_x;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_m2    = r_m2;
        n_dq    = r_dq;
        n_prod  = r_prod;
        n_ov    = r_ov;
        n_ocnt  = r_ocnt;
        n_omean = r_omean;
        n_ovar  = r_ovar;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_x     = w_xin;
                    n_cnt   = (&r_cnt) ? r_cnt : r_cnt + 1'b1;
                    n_state = S_MAG1;
                end
            end
            S_MAG1: begin
                n_neg   = w_lt;
                n_mag   = w_sum[XW-1:0];
                n_dq    = {w_sum[XW-1:0], {(DW - XW){1'b0}}};
                n_rem   = '0;
                n_dvs   = r_cnt;
                n_step  = SW'(XW - 1);
                n_state = S_DIV1;
            end
            S_DIV1, S_DIV2: begin
                // restoring divide, one quotient bit per cycle
                n_rem  = w_ge ? w_sum[COUNT_BITS-1:0] : w_part[COUNT_BITS-1:0];
                n_dq   = {r_dq[DW-2:0], w_ge};
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = (r_state == S_DIV1) ? S_MEAN : S_DONE;
                end
            end
            S_MEAN: begin
                n_mean  = w_sum[XW-1:0];
                n_state = S_MAG2;
            end
            S_MAG2: begin
                n_prod  = {{XW{1'b0}}, w_sum[XW-1:0]};
                n_step  = SW'(XW - 1);
                n_state = S_MUL;
            end
            S_MUL: begin
                // shift-add multiply, lsb of multiplier first
                n_prod = {w_sum[XW:0], r_prod[XW-1:1]};
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_m2    = w_sum[M2_W] ? '1 : w_sum[M2_W-1:0];
                n_state = w_low_cnt ? S_DONE : S_DEC;
            end
            S_DEC: begin
                n_dvs   = w_sum[COUNT_BITS-1:0];
                n_dq    = r_m2;
                n_rem   = '0;
                n_step  = SW'(DW - 1);
                n_state = S_DIV2;
            end
            S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_ov    = 1'b1;
                    n_ocnt  = COUNT_W'(r_cnt);
                    n_omean = MEAN_W'(r_mean);
                    if (w_low_cnt) begin
                        n_ovar = '0;
                    end else if (|r_dq[DW-1:VAR_W]) begin
                        n_ovar = '1;
                    end else begin
                        n_ovar = r_dq[VAR_W-1:0];
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_mean  <= '0;
            r_m2    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_mean  <= n_mean;
            r_m2    <= n_m2;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_dvs   <= n_dvs;
        r_rem   <= n_rem;
        r_x     <= n_x;
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_dq    <= n_dq;
        r_prod  <= n_prod;
        r_ocnt  <= n_ocnt;
        r_omean <= n_omean;
        r_ovar  <= n_ovar;
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_ov;
    assign o_out.sample_count    = r_ocnt;
    assign o_out.running_mean    = r_omean;
    assign o_out.sample_variance = r_ovar;

    // a result appears only from the final sequencer step
    a_ov_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_DONE))
        else $error("result register loaded outside final step");

    // divides never run with a zero divisor
    a_dvs_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV1 || r_state == S_DIV2) |-> r_dvs != '0)
        else $error("divide started with zero divisor");

    // a shown result always counts at least one sample
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.sample_count != '0)
        else $error("result with zero sample count");

    // variance is zero until the second sample
    a_var_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.sample_count == COUNT_W'(1)) |->
            o_out.sample_variance == '0)
        else $error("nonzero variance for a single sample");

endmodule

`default_nettype wire

// ===== sv/rmv_alu.sv =====
// shared add/subtract unit used for every arithmetic step of the sequencer
// depends on rmv_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmv_alu (
    input  logic [rmv_pkg::ALU_W-1:0] i_a,
    input  logic [rmv_pkg::ALU_W-1:0] i_b,
    input  rmv_pkg::t_alu_op          i_op,
    output logic [rmv_pkg::ALU_W:0]   o_sum
);
    import rmv_pkg::*;

    logic [ALU_W-1:0] w_b;
    logic [ALU_W:0]   w_cin;

    // subtract as a + ~b + 1; top bit is carry out, i.e. no borrow for subtract
    assign w_b   = (i_op == ALU_SUB) ? ~i_b : i_b;
    assign w_cin = (i_op == ALU_SUB) ? (ALU_W + 1)'(1'b1) : '0;
    assign o_sum = {1'b0, i_a} + {1'b0, w_b} + w_cin;

endmodule

`default_nettype wire
